@@ design/leb_pkg.sv @@
package leb_pkg;

	localparam int CHAR_W         = 8;
	localparam int CFG_IDX_W      = 3;
	localparam int LINE_DEPTH_DEF = 63;

	localparam logic [CHAR_W-1:0] LF_CODE    = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CODE = 8'd32;

	// register map of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ERASE_CHAR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERASE_WORD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KILL_LINE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NEWLINE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_END        = 3'd4;

	localparam logic [CHAR_W-1:0] RST_ERASE_CHAR = 8'd35;
	localparam logic [CHAR_W-1:0] RST_ERASE_WORD = 8'd36;
	localparam logic [CHAR_W-1:0] RST_KILL_LINE  = 8'd92;
	localparam logic [CHAR_W-1:0] RST_NEWLINE    = 8'd42;
	localparam logic [CHAR_W-1:0] RST_END        = 8'd126;

	// class of an incoming character, in priority order
	typedef enum logic [2:0] {
		OP_END,
		OP_ERASE_WORD,
		OP_ERASE_CHAR,
		OP_KILL,
		OP_NEWLINE,
		OP_PUSH
	} op_t;

	typedef struct packed {
		logic take;          // input beat accepted, hold the character
		logic push;          // write the incoming character on top
		logic push_held;     // write the held character on top
		logic cnt_dec;       // drop the top character
		logic cnt_clr;       // empty the buffer
		logic rd_top;        // read the top character and pop it
		logic idx_clr;       // restart the flush index
		logic rd_idx;        // read the character at the flush index
		logic load_char_out; // load read data into the output register
		logic load_end_out;  // load the line-end beat
	} leb_cmd_t;

	typedef struct packed {
		op_t  op;
		logic cnt_zero;
		logic cnt_full;
		logic idx_done;
		logic rdata_space;
		logic out_free;
	} leb_sts_t;

endpackage

@@ design/line_edit_buffer_top.sv @@
// line edit buffer: stack based line editor, one character per input beat
// in channel: in_valid/in_ready with in_char; a line feed is taken as a space
// cfg channel: cfg_valid/cfg_ready with cfg_index/cfg_data, always ready;
//   0 erase char, 1 erase word, 2 kill line, 3 newline, 4 end code
//   write only while the block is idle; other indexes are ignored
// out channel: out_valid/out_ready with out_char, char_present, line_end;
//   a flush sends the buffered characters oldest first, then a line-end beat
// steps: push, erase char and kill line complete as the beat is accepted; erase word
//   walks the buffer, a read then a check per popped character, until a space
//   has gone or the buffer runs dry; a flush reads and loads each character,
//   then sends the line-end beat, and a push into a full buffer follows it; the
//   store has one registered read port, which sets the read-then-use step of each walk
// the output register lets the next input beat in while the last result
//   still waits; a stalled receiver holds the flush walk, nothing is lost
// reset: buffer empty, control codes back to their defaults, no output
module line_edit_buffer_top #(
	parameter int LINE_DEPTH = leb_pkg::LINE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [leb_pkg::CHAR_W-1:0]    in_char,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [leb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [leb_pkg::CHAR_W-1:0]    cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [leb_pkg::CHAR_W-1:0]    out_char,
	output logic                          char_present,
	output logic                          line_end
);

	import leb_pkg::*;

	leb_cmd_t cmd;
	leb_sts_t sts;

	// controller: decides each step from the character class and counters
	leb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: config codes, fill count, line store, output register
	leb_dpath #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_char      (in_char),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_char     (out_char),
		.char_present (char_present),
		.line_end     (line_end),
		.cmd          (cmd),
		.sts          (sts)
	);

`ifndef ASSERT_OFF
	// never push onto a full buffer; the held push always lands on an empty one
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && sts.cnt_full) && !(cmd.push_held && !sts.cnt_zero))
		else $error("push into a full buffer");

	// a pending result is never overwritten
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_char_out || cmd.load_end_out) |-> sts.out_free)
		else $error("output register overwritten");

	// word erase never pops an empty buffer
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_top |-> !sts.cnt_zero)
		else $error("pop from an empty buffer");

	// a character beat is loaded into the output register only after its read
	a_read_before_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_char_out |-> $past(cmd.rd_idx) || $past(cmd.load_char_out) == 1'b0)
		else $error("character loaded without a read");
`endif

endmodule

@@ design/leb_ram.sv @@
module leb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 63
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/leb_ctrl.sv @@
module leb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  leb_pkg::leb_sts_t  sts,
	output leb_pkg::leb_cmd_t  cmd
);

	import leb_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_EW_RD  = 7'b0000010,
		S_EW_CHK = 7'b0000100,
		S_FL_RD  = 7'b0001000,
		S_FL_LD  = 7'b0010000,
		S_FL_END = 7'b0100000,
		S_PUSH   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   push_after_q, push_after_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			push_after_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			push_after_q <= push_after_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		push_after_d = push_after_q;
		cmd          = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					case (sts.op)
						OP_END: begin
							if (!sts.cnt_zero) begin
								cmd.idx_clr = 1'b1;
								state_d     = S_FL_RD;
							end
						end
						OP_ERASE_WORD: begin
							state_d = S_EW_RD;
						end
						OP_ERASE_CHAR: begin
							cmd.cnt_dec = !sts.cnt_zero;
						end
						OP_KILL: begin
							cmd.cnt_clr = 1'b1;
						end
						OP_NEWLINE: begin
							cmd.idx_clr = 1'b1;
							state_d     = S_FL_RD;
						end
						default: begin
							if (sts.cnt_full) begin
								// full buffer: flush, then push the held character
								cmd.idx_clr  = 1'b1;
								push_after_d = 1'b1;
								state_d      = S_FL_RD;
							end else begin
								cmd.push = 1'b1;
							end
						end
					endcase
				end
			end
			S_EW_RD: begin
				if (sts.cnt_zero) begin
					state_d = S_IDLE;
				end else begin
					cmd.rd_top = 1'b1;
					state_d    = S_EW_CHK;
				end
			end
			S_EW_CHK: begin
				state_d = sts.rdata_space ? S_IDLE : S_EW_RD;
			end
			S_FL_RD: begin
				if (sts.idx_done) begin
					state_d = S_FL_END;
				end else begin
					cmd.rd_idx = 1'b1;
					state_d    = S_FL_LD;
				end
			end
			S_FL_LD: begin
				if (sts.out_free) begin
					cmd.load_char_out = 1'b1;
					state_d           = S_FL_RD;
				end
			end
			S_FL_END: begin
				if (sts.out_free) begin
					cmd.load_end_out = 1'b1;
					cmd.cnt_clr      = 1'b1;
					state_d          = push_after_q ? S_PUSH : S_IDLE;
				end
			end
			S_PUSH: begin
				cmd.push_held = 1'b1;
				push_after_d  = 1'b0;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ design/leb_dpath.sv @@
module leb_dpath #(
	parameter int LINE_DEPTH = leb_pkg::LINE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [leb_pkg::CHAR_W-1:0]          in_char,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [leb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [leb_pkg::CHAR_W-1:0]          cfg_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [leb_pkg::CHAR_W-1:0]          out_char,
	output logic                                char_present,
	output logic                                line_end,
	input  leb_pkg::leb_cmd_t                   cmd,
	output leb_pkg::leb_sts_t                   sts
);

	import leb_pkg::*;

	localparam int CNT_W  = $clog2(LINE_DEPTH + 1);
	localparam int ADDR_W = $clog2(LINE_DEPTH);

	logic [CHAR_W-1:0] erase_char_q, erase_word_q, kill_line_q, newline_q, end_q;
	logic [CHAR_W-1:0] char_in, char_q, rdata, wdata;
	logic [CNT_W-1:0]  cnt_q, idx_q, cnt_m1;
	logic [ADDR_W-1:0] raddr;
	logic              out_valid_q, char_present_q, line_end_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_free;
	op_t               op;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_char_q <= RST_ERASE_CHAR;
			erase_word_q <= RST_ERASE_WORD;
			kill_line_q  <= RST_KILL_LINE;
			newline_q    <= RST_NEWLINE;
			end_q        <= RST_END;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ERASE_CHAR: erase_char_q <= cfg_data;
				REG_ERASE_WORD: erase_word_q <= cfg_data;
				REG_KILL_LINE:  kill_line_q  <= cfg_data;
				REG_NEWLINE:    newline_q    <= cfg_data;
				REG_END:        end_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// line feed counts as a space before any compare
	assign char_in = (in_char == LF_CODE) ? SPACE_CODE : in_char;

	always_comb begin
		if (char_in == end_q)             op = OP_END;
		else if (char_in == erase_word_q) op = OP_ERASE_WORD;
		else if (char_in == erase_char_q) op = OP_ERASE_CHAR;
		else if (char_in == kill_line_q)  op = OP_KILL;
		else if (char_in == newline_q)    op = OP_NEWLINE;
		else                              op = OP_PUSH;
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			char_q <= char_in;
		end
	end

	// fill count and flush index
	assign cnt_m1 = cnt_q - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.push || cmd.push_held) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.cnt_dec || cmd.rd_top) begin
				cnt_q <= cnt_m1;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.load_char_out) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	// line store
	assign wdata = cmd.push ? char_in : char_q;
	assign raddr = cmd.rd_top ? cnt_m1[ADDR_W-1:0] : idx_q[ADDR_W-1:0];

	leb_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(LINE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.push || cmd.push_held),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (wdata),
		.re    (cmd.rd_top || cmd.rd_idx),
		.raddr (raddr),
		.rdata (rdata)
	);

	// output register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_char_out || cmd.load_end_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_char_out) begin
			out_char_q     <= rdata;
			char_present_q <= 1'b1;
			line_end_q     <= 1'b0;
		end else if (cmd.load_end_out) begin
			out_char_q     <= '0;
			char_present_q <= 1'b0;
			line_end_q     <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_char     = out_char_q;
	assign char_present = char_present_q;
	assign line_end     = line_end_q;

	always_comb begin
		sts             = '0;
		sts.op          = op;
		sts.cnt_zero    = (cnt_q == '0);
		sts.cnt_full    = (cnt_q == CNT_W'(LINE_DEPTH));
		sts.idx_done    = (idx_q == cnt_q);
		sts.rdata_space = (rdata == SPACE_CODE);
		sts.out_free    = out_free;
	end

endmodule

@@ verif/line_edit_buffer_top_tb.sv @@
`timescale 1ns / 100ps

module line_edit_buffer_top_tb;
	import leb_pkg::*;

	localparam int DEPTH = LINE_DEPTH_DEF;
	// longest silent walk is an erase word over a full buffer
	localparam int SETTLE = 2 * DEPTH + 40;

	// one beat on the out channel
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              present;
		logic              last;
	} line_beat_t;

	// one row of the directed script; typed rows carry their own expected line
	typedef struct packed {
		logic [CHAR_W-1:0]      ch;
		logic                   typed;
		logic [2:0]             n_chars;
		logic [0:3][CHAR_W-1:0] lit;
		logic                   ends;
	} script_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [CHAR_W-1:0]    in_char   = '0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CHAR_W-1:0]    cfg_data  = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [CHAR_W-1:0]    out_char;
	logic                 char_present;
	logic                 line_end;

	// shadow copy of the control codes
	logic [CHAR_W-1:0] code_erase_char = RST_ERASE_CHAR;
	logic [CHAR_W-1:0] code_erase_word = RST_ERASE_WORD;
	logic [CHAR_W-1:0] code_kill       = RST_KILL_LINE;
	logic [CHAR_W-1:0] code_newline    = RST_NEWLINE;
	logic [CHAR_W-1:0] code_end        = RST_END;

	// shadow line buffer
	logic [CHAR_W-1:0] line_chars [DEPTH];
	int                line_len = 0;

	line_beat_t line_beats_due [$];
	line_beat_t want_beat;
	int         mismatches    = 0;
	int         chars_sent    = 0;
	int         send_idle_pct = 13;
	int         recv_idle_pct = 81;

	// directed script, walked right after reset with the default codes
	script_row_t script [0:23] = '{
		'{RST_NEWLINE,    1'b1, 3'd0, 32'h0, 1'b1},   // newline on empty buffer: bare line end
		'{RST_END,        1'b1, 3'd0, 32'h0, 1'b0},   // end on empty buffer: silent
		'{RST_ERASE_CHAR, 1'b1, 3'd0, 32'h0, 1'b0},   // erase char on empty buffer
		'{RST_ERASE_WORD, 1'b1, 3'd0, 32'h0, 1'b0},   // erase word on empty buffer
		'{8'h00,          1'b0, 3'd0, 32'h0, 1'b0},
		'{8'hff,          1'b0, 3'd0, 32'h0, 1'b0},
		'{LF_CODE,        1'b0, 3'd0, 32'h0, 1'b0},   // line feed goes in as a space
		'{8'h41,          1'b0, 3'd0, 32'h0, 1'b0},
		'{RST_NEWLINE,    1'b1, 3'd4, {8'h00, 8'hff, SPACE_CODE, 8'h41}, 1'b1},
		'{8'h42,          1'b0, 3'd0, 32'h0, 1'b0},
		'{SPACE_CODE,     1'b0, 3'd0, 32'h0, 1'b0},
		'{8'h43,          1'b0, 3'd0, 32'h0, 1'b0},
		'{8'h44,          1'b0, 3'd0, 32'h0, 1'b0},
		'{RST_ERASE_WORD, 1'b0, 3'd0, 32'h0, 1'b0},   // pops back through the space
		'{RST_ERASE_CHAR, 1'b0, 3'd0, 32'h0, 1'b0},
		'{8'h45,          1'b0, 3'd0, 32'h0, 1'b0},
		'{8'h46,          1'b0, 3'd0, 32'h0, 1'b0},
		'{RST_ERASE_WORD, 1'b0, 3'd0, 32'h0, 1'b0},   // no space left: stops at bottom
		'{8'h47,          1'b0, 3'd0, 32'h0, 1'b0},
		'{RST_KILL_LINE,  1'b0, 3'd0, 32'h0, 1'b0},
		'{8'h48,          1'b0, 3'd0, 32'h0, 1'b0},
		'{RST_END,        1'b1, 3'd1, {8'h48, 24'h0}, 1'b1},
		'{8'h80,          1'b0, 3'd0, 32'h0, 1'b0},   // stream goes on after end
		'{RST_NEWLINE,    1'b1, 3'd1, {8'h80, 24'h0}, 1'b1}
	};

	line_edit_buffer_top #(
		.LINE_DEPTH(DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_char     (in_char),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.char_present(char_present),
		.line_end    (line_end)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// line editor prediction
	// ---------------------------------------------------------------

	// class of a character after line feed mapping, highest priority first
	function automatic op_t classify(input logic [CHAR_W-1:0] c);
		if (c == code_end)        return OP_END;
		if (c == code_erase_word) return OP_ERASE_WORD;
		if (c == code_erase_char) return OP_ERASE_CHAR;
		if (c == code_kill)       return OP_KILL;
		if (c == code_newline)    return OP_NEWLINE;
		return OP_PUSH;
	endfunction

	// buffered characters oldest first, then the line-end beat
	function automatic void flush_line();
		for (int i = 0; i < line_len; i++)
			line_beats_due.push_back(line_beat_t'{line_chars[i], 1'b1, 1'b0});
		line_beats_due.push_back(line_beat_t'{'0, 1'b0, 1'b1});
		line_len = 0;
	endfunction

	function automatic void edit_char(input logic [CHAR_W-1:0] raw);
		logic [CHAR_W-1:0] c;
		bit                hit_space;
		c = (raw == LF_CODE) ? SPACE_CODE : raw;
		case (classify(c))
			OP_END: begin
				if (line_len != 0)
					flush_line();
			end
			OP_ERASE_WORD: begin
				// pop until a space has gone, or the buffer runs dry
				hit_space = 1'b0;
				while (line_len != 0 && !hit_space) begin
					line_len--;
					hit_space = (line_chars[line_len] == SPACE_CODE);
				end
			end
			OP_ERASE_CHAR: begin
				if (line_len != 0)
					line_len--;
			end
			OP_KILL: begin
				line_len = 0;
			end
			OP_NEWLINE: begin
				flush_line();
			end
			default: begin
				// a full buffer goes out as a line before the push
				if (line_len >= DEPTH)
					flush_line();
				line_chars[line_len] = c;
				line_len++;
			end
		endcase
	endfunction

	// random character that the current codes treat as text
	function automatic logic [CHAR_W-1:0] plain_char();
		logic [CHAR_W-1:0] c;
		do
			c = CHAR_W'($urandom_range(0, 255));
		while (classify((c == LF_CODE) ? SPACE_CODE : c) != OP_PUSH);
		return c;
	endfunction

	// ---------------------------------------------------------------
	// in channel
	// ---------------------------------------------------------------

	// one beat; returns in the time step of the accepting edge
	task automatic send_char(input logic [CHAR_W-1:0] c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_char  <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		chars_sent++;
		// idling profile: slow receiver, then slow sender, then full rate
		if (chars_sent < 110) begin
			send_idle_pct = 13;
			recv_idle_pct = 81;
		end else if (chars_sent < 220) begin
			send_idle_pct = 81;
			recv_idle_pct = 13;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	task automatic type_char(input logic [CHAR_W-1:0] c);
		send_char(c);
		edit_char(c);
	endtask

	// hold the in channel until every predicted beat is out and the walks are done
	task automatic drain();
		in_valid <= 1'b0;
		while (line_beats_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// cfg channel
	// ---------------------------------------------------------------

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHAR_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_ERASE_CHAR: code_erase_char = val;
			REG_ERASE_WORD: code_erase_word = val;
			REG_KILL_LINE:  code_kill       = val;
			REG_NEWLINE:    code_newline    = val;
			REG_END:        code_end        = val;
			default: ;
		endcase
	endtask

	// all five codes back to back; optionally junk to the unmapped indexes too
	task automatic write_codes(input logic [CHAR_W-1:0] v_ec, input logic [CHAR_W-1:0] v_ew,
			input logic [CHAR_W-1:0] v_kl, input logic [CHAR_W-1:0] v_nl,
			input logic [CHAR_W-1:0] v_en, input bit with_spare);
		write_reg(REG_ERASE_CHAR, v_ec);
		write_reg(REG_ERASE_WORD, v_ew);
		write_reg(REG_KILL_LINE, v_kl);
		write_reg(REG_NEWLINE, v_nl);
		write_reg(REG_END, v_en);
		if (with_spare) begin
			for (int i = REG_END + 1; i < 2 ** CFG_IDX_W; i++)
				write_reg(CFG_IDX_W'(i), CHAR_W'($urandom_range(0, 255)));
		end
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// random traffic
	// ---------------------------------------------------------------

	// text with edits (a long line has none), closed by newline or now and then by end;
	// a long line, up to eight past the buffer depth, can force the full-buffer flush
	task automatic type_line(input bit long_line);
		int len;
		int roll;
		len = long_line ? $urandom_range(DEPTH - 2, DEPTH + 8) : $urandom_range(1, 14);
		repeat (len) begin
			roll = $urandom_range(0, 99);
			if (roll < 10)
				type_char($urandom_range(0, 1) ? SPACE_CODE : LF_CODE);
			else if (long_line || roll >= 24)
				type_char(plain_char());
			else if (roll < 16)
				type_char(code_erase_char);
			else if (roll < 21)
				type_char(code_erase_word);
			else
				type_char(code_kill);
		end
		type_char(($urandom_range(0, 6) == 0) ? code_end : code_newline);
	endtask

	task automatic type_traffic(input int quota, input bit want_long);
		int stop_at;
		int roll;
		stop_at = chars_sent + quota;
		if (want_long)
			type_line(1'b1);
		while (chars_sent < stop_at) begin
			roll = $urandom_range(0, 99);
			if (roll < 12) begin
				// raw noise over the full character range
				repeat ($urandom_range(1, 6)) type_char(CHAR_W'($urandom_range(0, 255)));
			end else if (roll < 20) begin
				// broken line: some text, an edit or end, and no newline
				repeat ($urandom_range(0, 4)) type_char(plain_char());
				case ($urandom_range(0, 3))
					0:       type_char(code_erase_word);
					1:       type_char(code_kill);
					2:       type_char(code_end);
					default: type_char(code_erase_char);
				endcase
			end else begin
				type_line($urandom_range(0, 29) == 0);
			end
		end
	endtask

	// ---------------------------------------------------------------
	// out channel: random stalls and beat checking
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (line_beats_due.size() == 0) begin
				$display("%0t: beat with nothing due: out_char %02h char_present %b line_end %b",
					$time, out_char, char_present, line_end);
				mismatches++;
			end else begin
				want_beat = line_beats_due.pop_front();
				if (out_char !== want_beat.ch) begin
					$display("%0t: out_char expected %02h actual %02h",
						$time, want_beat.ch, out_char);
					mismatches++;
				end
				if (char_present !== want_beat.present) begin
					$display("%0t: char_present expected %b actual %b",
						$time, want_beat.present, char_present);
					mismatches++;
				end
				if (line_end !== want_beat.last) begin
					$display("%0t: line_end expected %b actual %b",
						$time, want_beat.last, line_end);
					mismatches++;
				end
			end
		end
		out_ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------

	initial begin
		int n_before;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed script with reset codes; typed rows replace the prediction
		foreach (script[r]) begin
			send_char(script[r].ch);
			n_before = line_beats_due.size();
			edit_char(script[r].ch);
			if (script[r].typed) begin
				while (line_beats_due.size() > n_before)
					void'(line_beats_due.pop_back());
				for (int i = 0; i < script[r].n_chars; i++)
					line_beats_due.push_back(line_beat_t'{script[r].lit[i], 1'b1, 1'b0});
				if (script[r].ends)
					line_beats_due.push_back(line_beat_t'{'0, 1'b0, 1'b1});
			end
		end
		type_traffic(60, 1'b1);

		// extremes; kill set to line feed can never match
		drain();
		write_codes(8'd0, 8'd255, LF_CODE, 8'd13, 8'd128, 1'b0);
		type_traffic(65, 1'b0);

		// equal codes: erase word shadows erase char and kill, end shadows newline
		drain();
		write_codes(8'd7, 8'd7, 8'd7, 8'd13, 8'd13, 1'b0);
		type_traffic(60, 1'b0);

		// other extremes; end shadows erase char
		drain();
		write_codes(8'd255, 8'd0, 8'd254, 8'd1, 8'd255, 1'b0);
		type_traffic(60, 1'b1);

		// back to the defaults, with junk to the unmapped indexes
		drain();
		write_codes(RST_ERASE_CHAR, RST_ERASE_WORD, RST_KILL_LINE, RST_NEWLINE, RST_END, 1'b1);
		type_traffic(60, 1'b0);

		drain();
		if (mismatches == 0 && line_beats_due.size() == 0) begin
			$display("line_edit_buffer_top regression: pass");
		end else begin
			$display("line_edit_buffer_top regression: fail");
		end
		$finish;
	end

	// hang guard, far above the slowest legal run
	initial begin
		#20_000_000;
		$display("line_edit_buffer_top regression: fail");
		$finish;
	end

endmodule
